/* rtl/adrp_pkg.sv */
// Shared types, constants and helper functions of the axis drag ray projection block.
package adrp_pkg;

    // Coordinate format and derived widths.
    localparam int COORD_W    = 32;
    localparam int FRAC_BITS  = 16;
    localparam int EPS_W      = 31;
    localparam int WIDE_W     = 3 * COORD_W + 8;
    localparam int DEN_W      = 2 * COORD_W + 4;
    localparam int DIG_W      = 8;
    localparam int MUL_DIGITS = COORD_W / DIG_W;
    localparam int MCNT_W     = $clog2(MUL_DIGITS + 1);
    localparam int DCNT_W     = $clog2(WIDE_W + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_W     = 4;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    // Axis codes.
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOK_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOK_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOK_Z  = 3'd4;

    // Multiply sequence landmarks.
    localparam logic [STEP_W-1:0] STEP_LINE_LAST = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CAM_FIRST = 4'd8;
    localparam logic [STEP_W-1:0] STEP_CAM_LAST  = 4'd14;

    typedef enum logic [1:0] {
        MODE_BEGIN     = 2'd0,
        MODE_APPLY     = 2'd1,
        MODE_END       = 2'd2,
        MODE_SET_PIVOT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_NOT_DRAG    = 2'd1,
        STAT_NO_SOLUTION = 2'd2
    } t_status;

    typedef enum logic [1:0] {ASRC_W, ASRC_X, ASRC_Q, ASRC_D} t_asrc;
    typedef enum logic {BSRC_D, BSRC_L} t_bsrc;
    typedef enum logic [2:0] {MDST_S, MDST_X, MDST_N, MDST_P, MDST_Q} t_mdst;
    typedef enum logic [1:0] {MACC_SET, MACC_ADD, MACC_SUB} t_macc;

    typedef struct packed {
        t_asrc      a_src;
        logic [1:0] a_idx;
        t_bsrc      b_src;
        logic [1:0] b_idx;
        t_mdst      dst;
        t_macc      acc;
    } t_mcmd;

    typedef enum logic [3:0] {
        DP_NOP, DP_CAPTURE, DP_START, DP_PREP, DP_MUL, DP_DIV,
        DP_SUB_WK, DP_SET_PARAM, DP_APPLY, DP_END, DP_SET_PIVOT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        t_mcmd      mul;
        logic [1:0] k;
        logic       div_cam;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic line_ok;
        logic cam_ok;
    } t_dp_stat;

    typedef struct packed {
        logic [EPS_W-1:0] epsilon;
        logic             camera_present;
        t_coord           look_x;
        t_coord           look_y;
        t_coord           look_z;
    } t_cfg;

    typedef struct packed {
        t_coord ray_origin_x;
        t_coord ray_origin_y;
        t_coord ray_origin_z;
        t_coord ray_dir_x;
        t_coord ray_dir_y;
        t_coord ray_dir_z;
        t_coord pivot_in_x;
        t_coord pivot_in_y;
        t_coord pivot_in_z;
    } t_ray_item;

    typedef enum logic [3:0] {
        CS_IDLE, CS_DECODE, CS_PREP, CS_MUL_GO, CS_MUL_WAIT, CS_CHK_LINE,
        CS_CHK_CAM, CS_DIV_WAIT, CS_FIX_T, CS_COMMIT, CS_DONE
    } t_ctrl_state;

    // Saturate a wide value to the coordinate range.
    function automatic t_coord f_sat(t_wide v);
        t_coord cmax;
        t_coord cmin;
        cmax = {1'b0, {(COORD_W-1){1'b1}}};
        cmin = {1'b1, {(COORD_W-1){1'b0}}};
        if (v > t_wide'(cmax)) begin
            return cmax;
        end else if (v < t_wide'(cmin)) begin
            return cmin;
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic t_mcmd f_mc(t_asrc as, logic [1:0] ai, t_bsrc bs, logic [1:0] bi,
                                   t_mdst d, t_macc ac);
        t_mcmd m;
        m.a_src = as;
        m.a_idx = ai;
        m.b_src = bs;
        m.b_idx = bi;
        m.dst   = d;
        m.acc   = ac;
        return m;
    endfunction

    // Multiply program: closest point terms first, then the camera plane terms.
    function automatic t_mcmd f_step(logic [STEP_W-1:0] step, logic [1:0] k);
        logic [1:0] i1;
        logic [1:0] i2;
        t_mcmd      m;
        i1 = (k == AXIS_X) ? AXIS_Y : AXIS_X;
        i2 = (k == AXIS_Z) ? AXIS_Y : AXIS_Z;
        case (step)
            4'd0:    m = f_mc(ASRC_D, i1, BSRC_D, i1, MDST_S, MACC_SET);
            4'd1:    m = f_mc(ASRC_D, i2, BSRC_D, i2, MDST_S, MACC_ADD);
            4'd2:    m = f_mc(ASRC_W, i1, BSRC_D, k,  MDST_X, MACC_SET);
            4'd3:    m = f_mc(ASRC_W, k,  BSRC_D, i1, MDST_X, MACC_SUB);
            4'd4:    m = f_mc(ASRC_X, i1, BSRC_D, i1, MDST_N, MACC_SET);
            4'd5:    m = f_mc(ASRC_W, i2, BSRC_D, k,  MDST_X, MACC_SET);
            4'd6:    m = f_mc(ASRC_W, k,  BSRC_D, i2, MDST_X, MACC_SUB);
            4'd7:    m = f_mc(ASRC_X, i2, BSRC_D, i2, MDST_N, MACC_ADD);
            4'd8:    m = f_mc(ASRC_D, AXIS_X, BSRC_L, AXIS_X, MDST_P, MACC_SET);
            4'd9:    m = f_mc(ASRC_D, AXIS_Y, BSRC_L, AXIS_Y, MDST_P, MACC_ADD);
            4'd10:   m = f_mc(ASRC_D, AXIS_Z, BSRC_L, AXIS_Z, MDST_P, MACC_ADD);
            4'd11:   m = f_mc(ASRC_W, AXIS_X, BSRC_L, AXIS_X, MDST_Q, MACC_SET);
            4'd12:   m = f_mc(ASRC_W, AXIS_Y, BSRC_L, AXIS_Y, MDST_Q, MACC_ADD);
            4'd13:   m = f_mc(ASRC_W, AXIS_Z, BSRC_L, AXIS_Z, MDST_Q, MACC_ADD);
            4'd14:   m = f_mc(ASRC_Q, k,  BSRC_D, k,  MDST_X, MACC_SET);
            default: m = f_mc(ASRC_D, i1, BSRC_D, i1, MDST_S, MACC_SET);
        endcase
        return m;
    endfunction

endpackage

/* rtl/adrp_in_if.sv */
// Input channel of the axis drag block: one drag event per beat.
interface adrp_in_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            mode;
    logic [1:0]            axis;
    adrp_pkg::t_coord      ray_origin_x;
    adrp_pkg::t_coord      ray_origin_y;
    adrp_pkg::t_coord      ray_origin_z;
    adrp_pkg::t_coord      ray_dir_x;
    adrp_pkg::t_coord      ray_dir_y;
    adrp_pkg::t_coord      ray_dir_z;
    adrp_pkg::t_coord      pivot_in_x;
    adrp_pkg::t_coord      pivot_in_y;
    adrp_pkg::t_coord      pivot_in_z;

    modport source (
        output valid, mode, axis, ray_origin_x, ray_origin_y, ray_origin_z,
               ray_dir_x, ray_dir_y, ray_dir_z, pivot_in_x, pivot_in_y, pivot_in_z,
        input  ready
    );
    modport sink (
        input  valid, mode, axis, ray_origin_x, ray_origin_y, ray_origin_z,
               ray_dir_x, ray_dir_y, ray_dir_z, pivot_in_x, pivot_in_y, pivot_in_z,
        output ready
    );
endinterface

/* rtl/adrp_out_if.sv */
// Output channel of the axis drag block: status and pivot per beat.
interface adrp_out_if;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    adrp_pkg::t_coord new_x;
    adrp_pkg::t_coord new_y;
    adrp_pkg::t_coord new_z;

    modport source (output valid, status, new_x, new_y, new_z, input ready);
    modport sink (input valid, status, new_x, new_y, new_z, output ready);
endinterface

/* rtl/adrp_dp.sv */
// Datapath: drag state, shared digit-serial multiplier and restoring divider.
module adrp_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  adrp_pkg::t_dp_cmd   i_cmd,
    input  adrp_pkg::t_cfg      i_cfg,
    input  adrp_pkg::t_ray_item i_item,
    output adrp_pkg::t_dp_stat  o_stat,
    output adrp_pkg::t_coord    o_pivot_x,
    output adrp_pkg::t_coord    o_pivot_y,
    output adrp_pkg::t_coord    o_pivot_z
);

    localparam int COORD_W = adrp_pkg::COORD_W;
    localparam int WIDE_W  = adrp_pkg::WIDE_W;
    localparam int DEN_W   = adrp_pkg::DEN_W;
    localparam int DIG_W   = adrp_pkg::DIG_W;

    function automatic adrp_pkg::t_coord f_pick(adrp_pkg::t_coord v0, adrp_pkg::t_coord v1,
                                                adrp_pkg::t_coord v2, logic [1:0] idx);
        adrp_pkg::t_coord r;
        case (idx)
            adrp_pkg::AXIS_X: r = v0;
            adrp_pkg::AXIS_Y: r = v1;
            default:          r = v2;
        endcase
        return r;
    endfunction

    function automatic logic signed [COORD_W:0] f_pickw(logic signed [COORD_W:0] v0,
                                                        logic signed [COORD_W:0] v1,
                                                        logic signed [COORD_W:0] v2,
                                                        logic [1:0] idx);
        logic signed [COORD_W:0] r;
        case (idx)
            adrp_pkg::AXIS_X: r = v0;
            adrp_pkg::AXIS_Y: r = v1;
            default:          r = v2;
        endcase
        return r;
    endfunction

    // Captured item and drag state.
    adrp_pkg::t_coord        r_o [3];
    adrp_pkg::t_coord        r_d [3];
    adrp_pkg::t_coord        r_pin [3];
    adrp_pkg::t_coord        r_start [3];
    adrp_pkg::t_coord        r_pivot [3];
    adrp_pkg::t_coord        r_sparam;
    logic signed [COORD_W:0] r_w [3];

    // Wide intermediates.
    adrp_pkg::t_wide         r_x;
    adrp_pkg::t_wide         r_n;
    adrp_pkg::t_wide         r_q;
    adrp_pkg::t_wide         r_t;
    logic signed [DEN_W-1:0] r_s;
    logic signed [DEN_W-1:0] r_p;

    // Multiplier state.
    adrp_pkg::t_wide                r_ma;
    adrp_pkg::t_coord               r_mb;
    adrp_pkg::t_wide                r_macc;
    logic [adrp_pkg::MCNT_W-1:0]    r_mcnt;
    logic                           r_mbusy;
    adrp_pkg::t_mcmd                r_mcmd;

    // Divider state.
    adrp_pkg::t_wide                r_dq;
    logic [DEN_W-1:0]               r_drem;
    logic [DEN_W-1:0]               r_dden;
    logic                           r_dneg;
    logic [adrp_pkg::DCNT_W-1:0]    r_dcnt;
    logic                           r_dbusy;

    adrp_pkg::t_wide                a_val;
    adrp_pkg::t_coord               b_val;
    logic signed [DIG_W:0]          dig;
    logic signed [WIDE_W+DIG_W:0]   prod;
    logic                           mul_done;
    adrp_pkg::t_wide                m_old;
    adrp_pkg::t_wide                m_res;
    adrp_pkg::t_wide                d_num;
    logic signed [DEN_W-1:0]        d_den;
    adrp_pkg::t_wide                d_num_abs;
    logic signed [DEN_W-1:0]        d_den_abs;
    logic [DEN_W:0]                 rem_sh;
    logic [DEN_W:0]                 rem_sub;
    logic                           rem_ge;
    logic                           div_done;
    logic [DEN_W-1:0]               thr;
    logic signed [DEN_W-1:0]        p_abs;
    adrp_pkg::t_wide                apply_sum;
    adrp_pkg::t_coord               start_k;

    // Multiplier operand selection.
    always_comb begin
        unique case (i_cmd.mul.a_src)
            adrp_pkg::ASRC_W: a_val = adrp_pkg::t_wide'(f_pickw(r_w[0], r_w[1], r_w[2],
                                                                i_cmd.mul.a_idx));
            adrp_pkg::ASRC_X: a_val = r_x;
            adrp_pkg::ASRC_Q: a_val = r_q;
            default:          a_val = adrp_pkg::t_wide'(f_pick(r_d[0], r_d[1], r_d[2],
                                                               i_cmd.mul.a_idx));
        endcase
        if (i_cmd.mul.b_src == adrp_pkg::BSRC_L) begin
            b_val = f_pick(i_cfg.look_x, i_cfg.look_y, i_cfg.look_z, i_cmd.mul.b_idx);
        end else begin
            b_val = f_pick(r_d[0], r_d[1], r_d[2], i_cmd.mul.b_idx);
        end
    end

    // One 8-bit digit of the coordinate operand per cycle; the top digit is signed.
    always_comb begin
        if (r_mcnt == adrp_pkg::MCNT_W'(adrp_pkg::MUL_DIGITS - 1)) begin
            dig = {r_mb[DIG_W-1], r_mb[DIG_W-1:0]};
        end else begin
            dig = {1'b0, r_mb[DIG_W-1:0]};
        end
        prod     = r_ma * dig;
        mul_done = r_mbusy && (r_mcnt == adrp_pkg::MCNT_W'(adrp_pkg::MUL_DIGITS));
        unique case (r_mcmd.dst)
            adrp_pkg::MDST_S: m_old = adrp_pkg::t_wide'(r_s);
            adrp_pkg::MDST_X: m_old = r_x;
            adrp_pkg::MDST_N: m_old = r_n;
            adrp_pkg::MDST_P: m_old = adrp_pkg::t_wide'(r_p);
            default:          m_old = r_q;
        endcase
        unique case (r_mcmd.acc)
            adrp_pkg::MACC_ADD: m_res = m_old + r_macc;
            adrp_pkg::MACC_SUB: m_res = m_old - r_macc;
            default:            m_res = r_macc;
        endcase
    end

    // Divider operands and one restoring step.
    always_comb begin
        d_num     = i_cmd.div_cam ? r_x : r_n;
        d_den     = i_cmd.div_cam ? r_p : r_s;
        d_num_abs = d_num[WIDE_W-1] ? -d_num : d_num;
        d_den_abs = d_den[DEN_W-1] ? -d_den : d_den;
        rem_sh    = {r_drem, r_dq[WIDE_W-1]};
        rem_sub   = rem_sh - {1'b0, r_dden};
        rem_ge    = rem_sh >= {1'b0, r_dden};
        div_done  = r_dbusy && (r_dcnt == adrp_pkg::DCNT_W'(WIDE_W));
    end

    // Degeneracy checks against epsilon in Q32.32.
    always_comb begin
        thr   = DEN_W'({i_cfg.epsilon, {adrp_pkg::FRAC_BITS{1'b0}}});
        p_abs = r_p[DEN_W-1] ? -r_p : r_p;
        o_stat.mul_done = mul_done;
        o_stat.div_done = div_done;
        o_stat.line_ok  = (r_s != '0) && ($unsigned(r_s) >= thr);
        o_stat.cam_ok   = (r_p != '0) && ($unsigned(p_abs) >= thr)
                          && ((r_q == '0) || (r_q[WIDE_W-1] == r_p[DEN_W-1]));
    end

    // New pivot coordinate along the drag axis.
    always_comb begin
        start_k   = f_pick(r_start[0], r_start[1], r_start[2], i_cmd.k);
        apply_sum = r_t - adrp_pkg::t_wide'(r_sparam) + adrp_pkg::t_wide'(start_k);
    end

    // Unit control: busy flags and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mcnt  <= '0;
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            if (i_cmd.op == adrp_pkg::DP_MUL) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= '0;
            end else if (mul_done) begin
                r_mbusy <= 1'b0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + 1'b1;
            end
            if (i_cmd.op == adrp_pkg::DP_DIV) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= '0;
            end else if (div_done) begin
                r_dbusy <= 1'b0;
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt + 1'b1;
            end
        end
    end

    // Working data: captured item, offsets, products and quotient.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == adrp_pkg::DP_CAPTURE) begin
            r_o[0]   <= i_item.ray_origin_x;
            r_o[1]   <= i_item.ray_origin_y;
            r_o[2]   <= i_item.ray_origin_z;
            r_d[0]   <= i_item.ray_dir_x;
            r_d[1]   <= i_item.ray_dir_y;
            r_d[2]   <= i_item.ray_dir_z;
            r_pin[0] <= i_item.pivot_in_x;
            r_pin[1] <= i_item.pivot_in_y;
            r_pin[2] <= i_item.pivot_in_z;
        end
        if (i_cmd.op == adrp_pkg::DP_PREP) begin
            for (int j = 0; j < 3; j++) begin
                r_w[j] <= (COORD_W+1)'(r_start[j]) - (COORD_W+1)'(r_o[j]);
            end
        end
        if (i_cmd.op == adrp_pkg::DP_MUL) begin
            r_ma   <= a_val;
            r_mb   <= b_val;
            r_macc <= '0;
            r_mcmd <= i_cmd.mul;
        end else if (mul_done) begin
            unique case (r_mcmd.dst)
                adrp_pkg::MDST_S: r_s <= m_res[DEN_W-1:0];
                adrp_pkg::MDST_X: r_x <= m_res;
                adrp_pkg::MDST_N: r_n <= m_res;
                adrp_pkg::MDST_P: r_p <= m_res[DEN_W-1:0];
                default:          r_q <= m_res;
            endcase
        end else if (r_mbusy) begin
            r_macc <= r_macc + prod[WIDE_W-1:0];
            r_ma   <= r_ma <<< DIG_W;
            r_mb   <= r_mb >>> DIG_W;
        end
        if (i_cmd.op == adrp_pkg::DP_DIV) begin
            r_dq   <= d_num_abs;
            r_drem <= '0;
            r_dden <= d_den_abs;
            r_dneg <= d_num[WIDE_W-1] ^ d_den[DEN_W-1];
        end else if (div_done) begin
            r_t <= r_dneg ? -r_dq : r_dq;
        end else if (r_dbusy) begin
            r_drem <= rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_dq   <= {r_dq[WIDE_W-2:0], rem_ge};
        end
        if (i_cmd.op == adrp_pkg::DP_SUB_WK) begin
            r_t <= r_t - adrp_pkg::t_wide'(f_pickw(r_w[0], r_w[1], r_w[2], i_cmd.k));
        end
    end

    // Drag state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 3; j++) begin
                r_start[j] <= '0;
                r_pivot[j] <= '0;
            end
            r_sparam <= '0;
        end else begin
            unique case (i_cmd.op)
                adrp_pkg::DP_START: begin
                    for (int j = 0; j < 3; j++) r_start[j] <= r_pivot[j];
                end
                adrp_pkg::DP_END: begin
                    for (int j = 0; j < 3; j++) r_start[j] <= '0;
                    r_sparam <= '0;
                end
                adrp_pkg::DP_SET_PIVOT: begin
                    for (int j = 0; j < 3; j++) r_pivot[j] <= r_pin[j];
                end
                adrp_pkg::DP_SET_PARAM: begin
                    r_sparam <= adrp_pkg::f_sat(r_t);
                end
                adrp_pkg::DP_APPLY: begin
                    for (int j = 0; j < 3; j++) begin
                        r_pivot[j] <= (i_cmd.k == 2'(j)) ? adrp_pkg::f_sat(apply_sum)
                                                          : r_start[j];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_pivot_x = r_pivot[0];
    assign o_pivot_y = r_pivot[1];
    assign o_pivot_z = r_pivot[2];

endmodule

/* rtl/adrp_ctrl.sv */
// Controller: sequences capture for each drag event, and multiplies, divide and commit for begin and apply.
module adrp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_mode,
    input  logic [1:0]         i_axis,
    input  logic               i_out_free,
    input  logic               i_camera_present,
    input  adrp_pkg::t_dp_stat i_stat,
    output adrp_pkg::t_dp_cmd  o_cmd,
    output logic               o_in_ready,
    output logic               o_out_load,
    output adrp_pkg::t_status  o_status
);

    adrp_pkg::t_ctrl_state              r_state, n_state;
    logic [1:0]                         r_mode, n_mode;
    logic [1:0]                         r_axis, n_axis;
    logic [1:0]                         r_k, n_k;
    logic [adrp_pkg::STEP_W-1:0]        r_step, n_step;
    logic                               r_cam, n_cam;
    logic                               r_dragging, n_dragging;
    logic [1:0]                         r_drag_axis, n_drag_axis;
    adrp_pkg::t_status                  r_status, n_status;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= adrp_pkg::CS_IDLE;
            r_mode      <= adrp_pkg::MODE_BEGIN;
            r_axis      <= adrp_pkg::AXIS_NONE;
            r_k         <= adrp_pkg::AXIS_X;
            r_step      <= '0;
            r_cam       <= 1'b0;
            r_dragging  <= 1'b0;
            r_drag_axis <= adrp_pkg::AXIS_NONE;
            r_status    <= adrp_pkg::STAT_OK;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_axis      <= n_axis;
            r_k         <= n_k;
            r_step      <= n_step;
            r_cam       <= n_cam;
            r_dragging  <= n_dragging;
            r_drag_axis <= n_drag_axis;
            r_status    <= n_status;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_axis      = r_axis;
        n_k         = r_k;
        n_step      = r_step;
        n_cam       = r_cam;
        n_dragging  = r_dragging;
        n_drag_axis = r_drag_axis;
        n_status    = r_status;
        o_cmd.op      = adrp_pkg::DP_NOP;
        o_cmd.mul     = adrp_pkg::f_step(r_step, r_k);
        o_cmd.k       = r_k;
        o_cmd.div_cam = r_cam;
        o_in_ready    = 1'b0;
        o_out_load    = 1'b0;
        unique case (r_state)
            adrp_pkg::CS_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = adrp_pkg::DP_CAPTURE;
                    n_mode   = i_mode;
                    n_axis   = i_axis;
                    n_state  = adrp_pkg::CS_DECODE;
                end
            end
            adrp_pkg::CS_DECODE: begin
                n_status = adrp_pkg::STAT_OK;
                n_state  = adrp_pkg::CS_DONE;
                unique case (r_mode)
                    adrp_pkg::MODE_BEGIN: begin
                        if (r_axis == adrp_pkg::AXIS_NONE) begin
                            n_status = adrp_pkg::STAT_NOT_DRAG;
                        end else begin
                            o_cmd.op    = adrp_pkg::DP_START;
                            n_drag_axis = r_axis;
                            n_k         = r_axis;
                            n_state     = adrp_pkg::CS_PREP;
                        end
                    end
                    adrp_pkg::MODE_APPLY: begin
                        if (!r_dragging || r_drag_axis == adrp_pkg::AXIS_NONE) begin
                            n_status = adrp_pkg::STAT_NOT_DRAG;
                        end else begin
                            n_k     = r_drag_axis;
                            n_state = adrp_pkg::CS_PREP;
                        end
                    end
                    adrp_pkg::MODE_END: begin
                        o_cmd.op    = adrp_pkg::DP_END;
                        n_dragging  = 1'b0;
                        n_drag_axis = adrp_pkg::AXIS_NONE;
                    end
                    default: begin
                        o_cmd.op = adrp_pkg::DP_SET_PIVOT;
                    end
                endcase
            end
            adrp_pkg::CS_PREP: begin
                o_cmd.op = adrp_pkg::DP_PREP;
                n_step   = '0;
                n_state  = adrp_pkg::CS_MUL_GO;
            end
            adrp_pkg::CS_MUL_GO: begin
                o_cmd.op = adrp_pkg::DP_MUL;
                n_state  = adrp_pkg::CS_MUL_WAIT;
            end
            adrp_pkg::CS_MUL_WAIT: begin
                if (i_stat.mul_done) begin
                    if (r_step == adrp_pkg::STEP_LINE_LAST) begin
                        n_state = adrp_pkg::CS_CHK_LINE;
                    end else if (r_step == adrp_pkg::STEP_CAM_LAST) begin
                        n_state = adrp_pkg::CS_CHK_CAM;
                    end else begin
                        n_step  = r_step + 1'b1;
                        n_state = adrp_pkg::CS_MUL_GO;
                    end
                end
            end
            adrp_pkg::CS_CHK_LINE: begin
                if (i_stat.line_ok) begin
                    o_cmd.op      = adrp_pkg::DP_DIV;
                    o_cmd.div_cam = 1'b0;
                    n_cam         = 1'b0;
                    n_state       = adrp_pkg::CS_DIV_WAIT;
                end else if (i_camera_present) begin
                    n_step  = adrp_pkg::STEP_CAM_FIRST;
                    n_state = adrp_pkg::CS_MUL_GO;
                end else begin
                    n_status = adrp_pkg::STAT_NO_SOLUTION;
                    n_state  = adrp_pkg::CS_DONE;
                end
            end
            adrp_pkg::CS_CHK_CAM: begin
                if (i_stat.cam_ok) begin
                    o_cmd.op      = adrp_pkg::DP_DIV;
                    o_cmd.div_cam = 1'b1;
                    n_cam         = 1'b1;
                    n_state       = adrp_pkg::CS_DIV_WAIT;
                end else begin
                    n_status = adrp_pkg::STAT_NO_SOLUTION;
                    n_state  = adrp_pkg::CS_DONE;
                end
            end
            adrp_pkg::CS_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = r_cam ? adrp_pkg::CS_FIX_T : adrp_pkg::CS_COMMIT;
                end
            end
            adrp_pkg::CS_FIX_T: begin
                o_cmd.op = adrp_pkg::DP_SUB_WK;
                n_state  = adrp_pkg::CS_COMMIT;
            end
            adrp_pkg::CS_COMMIT: begin
                if (r_mode == adrp_pkg::MODE_BEGIN) begin
                    o_cmd.op   = adrp_pkg::DP_SET_PARAM;
                    n_dragging = 1'b1;
                end else begin
                    o_cmd.op = adrp_pkg::DP_APPLY;
                end
                n_state = adrp_pkg::CS_DONE;
            end
            adrp_pkg::CS_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = adrp_pkg::CS_IDLE;
                end
            end
            default: begin
                n_state = adrp_pkg::CS_IDLE;
            end
        endcase
    end

    assign o_status = r_status;

endmodule

/* rtl/axis_drag_ray_projection_core.sv */
// Top level of the axis drag ray projection block: config registers, result register.
//
// Each beat on the input channel is one drag event in Q16.16 and yields exactly one result
// beat carrying a status and the pivot after the event. Events are processed one at a time.
// End drag, set pivot and rejected events use no multiply or divide. Begin and apply use
// the closest point between ray and axis, or the camera-facing plane fallback when that
// is degenerate; both run on the shared multiplier (one 8-bit digit of a coordinate per
// cycle, 8 or 15 products) and on the restoring divider, which retires one quotient bit
// per cycle over 104 bits. A finished result waits in an output register; a new event is
// taken once the previous result has been loaded there.
module axis_drag_ray_projection_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    adrp_in_if.sink                            i_item,
    adrp_out_if.source                         o_result,
    input  logic                               i_cfg_we,
    input  logic [adrp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [adrp_pkg::COORD_W-1:0]       i_cfg_data
);

    adrp_pkg::t_cfg      r_cfg;
    adrp_pkg::t_ray_item w_item;
    adrp_pkg::t_dp_cmd   w_cmd;
    adrp_pkg::t_dp_stat  w_stat;
    adrp_pkg::t_status   w_status;
    adrp_pkg::t_coord    w_px, w_py, w_pz;
    logic                w_out_load;
    logic                w_in_ready;
    logic                r_ovalid;
    adrp_pkg::t_status   r_ostatus;
    adrp_pkg::t_coord    r_ox, r_oy, r_oz;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.epsilon        <= adrp_pkg::EPS_W'(1);
            r_cfg.camera_present <= 1'b0;
            r_cfg.look_x         <= '0;
            r_cfg.look_y         <= '0;
            r_cfg.look_z         <= adrp_pkg::COORD_W'(1) << adrp_pkg::FRAC_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                adrp_pkg::CFG_EPSILON: r_cfg.epsilon <= i_cfg_data[adrp_pkg::EPS_W-1:0];
                adrp_pkg::CFG_CAMERA:  r_cfg.camera_present <= i_cfg_data[0];
                adrp_pkg::CFG_LOOK_X:  r_cfg.look_x <= i_cfg_data;
                adrp_pkg::CFG_LOOK_Y:  r_cfg.look_y <= i_cfg_data;
                adrp_pkg::CFG_LOOK_Z:  r_cfg.look_z <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input beat payload for the datapath.
    always_comb begin
        w_item.ray_origin_x = i_item.ray_origin_x;
        w_item.ray_origin_y = i_item.ray_origin_y;
        w_item.ray_origin_z = i_item.ray_origin_z;
        w_item.ray_dir_x    = i_item.ray_dir_x;
        w_item.ray_dir_y    = i_item.ray_dir_y;
        w_item.ray_dir_z    = i_item.ray_dir_z;
        w_item.pivot_in_x   = i_item.pivot_in_x;
        w_item.pivot_in_y   = i_item.pivot_in_y;
        w_item.pivot_in_z   = i_item.pivot_in_z;
    end

    assign i_item.ready = w_in_ready;

    adrp_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_item.valid),
        .i_mode           (i_item.mode),
        .i_axis           (i_item.axis),
        .i_out_free       (!r_ovalid || o_result.ready),
        .i_camera_present (r_cfg.camera_present),
        .i_stat           (w_stat),
        .o_cmd            (w_cmd),
        .o_in_ready       (w_in_ready),
        .o_out_load       (w_out_load),
        .o_status         (w_status)
    );

    adrp_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_cfg     (r_cfg),
        .i_item    (w_item),
        .o_stat    (w_stat),
        .o_pivot_x (w_px),
        .o_pivot_y (w_py),
        .o_pivot_z (w_pz)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_result.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_ostatus <= w_status;
            r_ox      <= w_px;
            r_oy      <= w_py;
            r_oz      <= w_pz;
        end
    end

    assign o_result.valid  = r_ovalid;
    assign o_result.status = r_ostatus;
    assign o_result.new_x  = r_ox;
    assign o_result.new_y  = r_oy;
    assign o_result.new_z  = r_oz;

    // An accepted event keeps the input closed on the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && w_in_ready) |=> !w_in_ready)
        else $error("input accepted while an event is in progress");

    // The multiplier and divider never finish in the same cycle.
    a_unit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.mul_done && w_stat.div_done))
        else $error("multiplier and divider completed together");

    // A result is only loaded into a free output register.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_ovalid || o_result.ready))
        else $error("result overwrote a pending beat");

endmodule
